@@ rtl/ntag_pkg.sv @@
// shared types, constants and helpers for the transpose address generator
`default_nettype none

package ntag_pkg;

	// offset and configuration widths
	localparam int OFS_W          = 48;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 13;
	localparam int NUM_SIZE_REGS  = 4;
	localparam int PLACE_W        = 8;
	localparam int REV_W          = 4;

	// parameter defaults
	localparam int DEF_MAX_AXES   = 4;
	localparam int DEF_AXIS_BITS  = 12;

	// register reset values
	localparam logic [CFG_DATA_W-1:0] SIZE_RESET  = CFG_DATA_W'(1);
	localparam logic [PLACE_W-1:0]    PLACE_RESET = 8'd228;
	localparam logic [REV_W-1:0]      REV_RESET   = '0;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AXIS_SIZE_0    = 3'd0,
		REG_AXIS_SIZE_1    = 3'd1,
		REG_AXIS_SIZE_2    = 3'd2,
		REG_AXIS_SIZE_3    = 3'd3,
		REG_AXIS_PLACEMENT = 3'd4,
		REG_REVERSE_MASK   = 3'd5
	} ntag_reg_t;

	// status of the stride derivation sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} ntag_drv_status_t;

	// placement field reduced modulo the axis count
	function automatic logic [1:0] place_mod(input logic [1:0] field, input int axes);
		logic [2:0] v;
		v = {1'b0, field};
		for (int k = 0; k < 3; k++) begin
			if (32'(v) >= axes) begin
				v = v - 3'(axes);
			end
		end
		return v[1:0];
	endfunction

endpackage

`default_nettype wire

@@ rtl/nd_transpose_address_generator_core.sv @@
// top level: configuration registers, odometer walk and result register
`default_nettype none

// Each accepted beat on the input channel yields one result beat carrying the
// source offset, the destination offset and the last flag of the current
// element, then the row-major odometer advances one axis per cycle starting
// at the innermost axis, through every axis the carry passes (1 to MAX_AXES);
// the odometer walk uses a single 48-bit adder pair. A write to a known register
// restarts the traversal and reruns the stride derivation on one shared
// multiplier, with the input held not ready. The result sits in an output
// register, so a new item can be accepted in the cycle its predecessor's
// result is taken, once the predecessor's walk has finished.
module nd_transpose_address_generator_core #(
	parameter int MAX_AXES  = ntag_pkg::DEF_MAX_AXES,
	parameter int AXIS_BITS = ntag_pkg::DEF_AXIS_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            restart,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ntag_pkg::OFS_W-1:0]      src_offset,
	output logic [ntag_pkg::OFS_W-1:0]      dst_offset,
	output logic                            last,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ntag_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ntag_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ntag_pkg::*;

	localparam int ES_W  = AXIS_BITS + 1;
	localparam int IDX_W = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
	localparam logic [31:0]      SIZE_CAP = 32'(1) << AXIS_BITS;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_AXES - 1);

	typedef enum logic [1:0] {
		T_IDLE = 2'b01,
		T_WALK = 2'b10
	} walk_state_t;

	// configuration registers
	logic [CFG_DATA_W-1:0] size_q [NUM_SIZE_REGS];
	logic [PLACE_W-1:0]    place_q;
	logic [REV_W-1:0]      rev_q;
	logic                  cfg_hit;

	// traversal state
	walk_state_t           state_q;
	logic [IDX_W-1:0]      axis_q;
	logic [AXIS_BITS-1:0]  coord_q [MAX_AXES];
	logic [OFS_W-1:0]      src_pos_q;
	logic [OFS_W-1:0]      dst_pos_q;

	// result register
	logic                  out_valid_q;
	logic [OFS_W-1:0]      src_offset_q;
	logic [OFS_W-1:0]      dst_offset_q;
	logic                  last_q;

	// derived values
	logic [ES_W-1:0]       eff [MAX_AXES];
	logic [IDX_W-1:0]      place [MAX_AXES];
	logic [MAX_AXES-1:0]   rev_d;
	logic [OFS_W-1:0]      src_step [MAX_AXES];
	logic [OFS_W-1:0]      src_back [MAX_AXES];
	logic [OFS_W-1:0]      dst_step [MAX_AXES];
	logic [OFS_W-1:0]      dst_back [MAX_AXES];
	logic [OFS_W-1:0]      base;
	ntag_drv_status_t      drv_st;

	logic                  in_beat;
	logic                  cfg_beat;
	logic                  last_now;
	logic [ES_W-1:0]       lim;
	logic                  can_inc;
	logic                  coord_ok;

	// effective sizes, placements and reversal per axis
	for (genvar i = 0; i < MAX_AXES; i++) begin : g_axis
		if (i < NUM_SIZE_REGS) begin : g_cfg
			logic [31:0] sz;
			always_comb begin
				sz = 32'(size_q[i]);
				if (sz == '0) begin
					sz = 32'(1);
				end
				if (sz > SIZE_CAP) begin
					sz = SIZE_CAP;
				end
				eff[i] = ES_W'(sz);
			end
			assign place[i] = IDX_W'(place_mod(place_q[2*i +: 2], MAX_AXES));
			assign rev_d[i] = rev_q[i];
		end else begin : g_fix
			assign eff[i]   = ES_W'(1);
			assign place[i] = IDX_W'(i);
			assign rev_d[i] = 1'b0;
		end
	end

	ntag_derive #(
		.MAX_AXES  (MAX_AXES),
		.AXIS_BITS (AXIS_BITS)
	) u_derive (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cfg_hit),
		.eff      (eff),
		.place    (place),
		.rev_d    (rev_d),
		.src_step (src_step),
		.src_back (src_back),
		.dst_step (dst_step),
		.dst_back (dst_back),
		.base     (base),
		.status   (drv_st)
	);

	// handshakes
	assign cfg_ready = 1'b1;
	assign cfg_beat  = cfg_valid && cfg_ready;
	assign cfg_hit   = cfg_beat && (cfg_index <= REG_REVERSE_MASK);
	assign in_ready  = (state_q == T_IDLE) && !drv_st.busy && !cfg_valid
		&& (!out_valid_q || out_ready);
	assign in_beat   = in_valid && in_ready;

	// last flag of the element about to be emitted
	always_comb begin
		last_now = 1'b1;
		for (int i = 0; i < MAX_AXES; i++) begin
			if (ES_W'(restart ? '0 : coord_q[i]) != eff[i] - ES_W'(1)) begin
				last_now = 1'b0;
			end
		end
	end

	// odometer compare for the current axis
	assign lim     = eff[axis_q] - ES_W'(1);
	assign can_inc = ES_W'(coord_q[axis_q]) < lim;

	// configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_SIZE_REGS; k++) begin
				size_q[k] <= SIZE_RESET;
			end
			place_q <= PLACE_RESET;
			rev_q   <= REV_RESET;
		end else if (cfg_beat) begin
			case (cfg_index) inside
				[REG_AXIS_SIZE_0:REG_AXIS_SIZE_3]: begin
					size_q[cfg_index[1:0]] <= cfg_data;
				end
				REG_AXIS_PLACEMENT: begin
					place_q <= cfg_data[PLACE_W-1:0];
				end
				REG_REVERSE_MASK: begin
					rev_q <= cfg_data[REV_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// traversal: emit on accept, then walk the carry one axis a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= T_IDLE;
			axis_q    <= IDX_LAST;
			src_pos_q <= '0;
			dst_pos_q <= '0;
			for (int k = 0; k < MAX_AXES; k++) begin
				coord_q[k] <= '0;
			end
		end else if (cfg_hit) begin
			state_q   <= T_IDLE;
			axis_q    <= IDX_LAST;
			src_pos_q <= '0;
			for (int k = 0; k < MAX_AXES; k++) begin
				coord_q[k] <= '0;
			end
		end else if (drv_st.done) begin
			dst_pos_q <= base;
		end else begin
			case (state_q)
				T_IDLE: begin
					if (in_beat) begin
						if (restart) begin
							src_pos_q <= '0;
							dst_pos_q <= base;
							for (int k = 0; k < MAX_AXES; k++) begin
								coord_q[k] <= '0;
							end
						end
						axis_q  <= IDX_LAST;
						state_q <= T_WALK;
					end
				end
				T_WALK: begin
					if (can_inc) begin
						coord_q[axis_q] <= coord_q[axis_q] + AXIS_BITS'(1);
						src_pos_q       <= src_pos_q + src_step[axis_q];
						dst_pos_q       <= dst_pos_q + dst_step[axis_q];
						state_q         <= T_IDLE;
					end else begin
						coord_q[axis_q] <= '0;
						src_pos_q       <= src_pos_q - src_back[axis_q];
						dst_pos_q       <= dst_pos_q - dst_back[axis_q];
						if (axis_q == '0) begin
							state_q <= T_IDLE;
						end else begin
							axis_q <= axis_q - IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_beat) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			src_offset_q <= restart ? '0 : src_pos_q;
			dst_offset_q <= restart ? base : dst_pos_q;
			last_q       <= last_now;
		end
	end

	assign out_valid  = out_valid_q;
	assign src_offset = src_offset_q;
	assign dst_offset = dst_offset_q;
	assign last       = last_q;

	// every coordinate stays within its axis
	always_comb begin
		coord_ok = 1'b1;
		for (int i = 0; i < MAX_AXES; i++) begin
			if (ES_W'(coord_q[i]) > eff[i] - ES_W'(1)) begin
				coord_ok = 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_beat_yields_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> out_valid)
		else $error("accepted beat did not produce a result");

	a_cfg_starts_derive: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_hit |=> (drv_st.busy && state_q == T_IDLE))
		else $error("register write did not start stride derivation");

	a_derive_loads_base: assert property (@(posedge clk) disable iff (!arst_n)
		(drv_st.done && !cfg_hit) |=> (dst_pos_q == base && src_pos_q == '0))
		else $error("traversal not restarted at start offset after derivation");

	a_coord_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!drv_st.busy |-> coord_ok)
		else $error("coordinate beyond axis size");
`endif

endmodule

`default_nettype wire

@@ rtl/ntag_derive.sv @@
// stride, backstride and start offset derivation on a shared multiplier
`default_nettype none

module ntag_derive #(
	parameter int MAX_AXES  = ntag_pkg::DEF_MAX_AXES,
	parameter int AXIS_BITS = ntag_pkg::DEF_AXIS_BITS,
	localparam int ES_W  = AXIS_BITS + 1,
	localparam int IDX_W = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ES_W-1:0]            eff [MAX_AXES],
	input  logic [IDX_W-1:0]           place [MAX_AXES],
	input  logic [MAX_AXES-1:0]        rev_d,
	output logic [ntag_pkg::OFS_W-1:0] src_step [MAX_AXES],
	output logic [ntag_pkg::OFS_W-1:0] src_back [MAX_AXES],
	output logic [ntag_pkg::OFS_W-1:0] dst_step [MAX_AXES],
	output logic [ntag_pkg::OFS_W-1:0] dst_back [MAX_AXES],
	output logic [ntag_pkg::OFS_W-1:0] base,
	output ntag_pkg::ntag_drv_status_t status
);
	import ntag_pkg::*;

	typedef enum logic [6:0] {
		D_IDLE    = 7'b0000001,
		D_SRC_MUL = 7'b0000010,
		D_SRC_UPD = 7'b0000100,
		D_DST_MUL = 7'b0001000,
		D_DST_UPD = 7'b0010000,
		D_BCK_MUL = 7'b0100000,
		D_BCK_UPD = 7'b1000000
	} drv_state_t;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_AXES - 1);

	drv_state_t        state_q;
	logic [IDX_W-1:0]  idx_q;
	logic [OFS_W-1:0]  stride_q;
	logic [OFS_W-1:0]  mul_q;
	logic [OFS_W-1:0]  st_q;
	logic [OFS_W-1:0]  base_q;
	logic [OFS_W-1:0]  dstride_q [MAX_AXES];
	logic [OFS_W-1:0]  src_step_q [MAX_AXES];
	logic [OFS_W-1:0]  src_back_q [MAX_AXES];
	logic [OFS_W-1:0]  dst_step_q [MAX_AXES];
	logic [OFS_W-1:0]  dst_back_q [MAX_AXES];

	logic [ES_W-1:0]   dsize [MAX_AXES];
	logic [IDX_W-1:0]  pd;
	logic [OFS_W-1:0]  st;
	logic [OFS_W-1:0]  mul_a;
	logic [ES_W-1:0]   mul_b;
	logic [OFS_W-1:0]  prod;

	// destination sizes: highest source axis placed on each wins
	always_comb begin
		for (int d = 0; d < MAX_AXES; d++) begin
			dsize[d] = ES_W'(1);
			for (int i = 0; i < MAX_AXES; i++) begin
				if (place[i] == IDX_W'(d)) begin
					dsize[d] = eff[i];
				end
			end
		end
	end

	// signed destination stride of the current source axis
	assign pd = place[idx_q];
	assign st = rev_d[pd] ? (OFS_W'(0) - dstride_q[pd]) : dstride_q[pd];

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			D_DST_MUL: begin
				mul_a = stride_q;
				mul_b = dsize[idx_q];
			end
			D_BCK_MUL: begin
				mul_a = st;
				mul_b = eff[idx_q];
			end
			default: begin
				mul_a = stride_q;
				mul_b = eff[idx_q];
			end
		endcase
	end

	assign prod = OFS_W'(mul_a * mul_b);

	// sequencer: a multiply state and an update state per axis, three passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= D_IDLE;
			idx_q    <= IDX_LAST;
			stride_q <= OFS_W'(1);
			mul_q    <= '0;
			st_q     <= '0;
			base_q   <= '0;
			for (int k = 0; k < MAX_AXES; k++) begin
				dstride_q[k]  <= OFS_W'(1);
				src_step_q[k] <= OFS_W'(1);
				src_back_q[k] <= '0;
				dst_step_q[k] <= OFS_W'(1);
				dst_back_q[k] <= '0;
			end
		end else if (start) begin
			state_q  <= D_SRC_MUL;
			idx_q    <= IDX_LAST;
			stride_q <= OFS_W'(1);
		end else begin
			case (state_q)
				D_IDLE: begin
				end
				D_SRC_MUL: begin
					mul_q   <= prod;
					state_q <= D_SRC_UPD;
				end
				D_SRC_UPD: begin
					src_step_q[idx_q] <= stride_q;
					src_back_q[idx_q] <= mul_q - stride_q;
					if (idx_q == '0) begin
						stride_q <= OFS_W'(1);
						base_q   <= '0;
						idx_q    <= IDX_LAST;
						state_q  <= D_DST_MUL;
					end else begin
						stride_q <= mul_q;
						idx_q    <= idx_q - IDX_W'(1);
						state_q  <= D_SRC_MUL;
					end
				end
				D_DST_MUL: begin
					mul_q   <= prod;
					state_q <= D_DST_UPD;
				end
				D_DST_UPD: begin
					dstride_q[idx_q] <= stride_q;
					if (rev_d[idx_q]) begin
						base_q <= base_q + mul_q - stride_q;
					end
					stride_q <= mul_q;
					if (idx_q == '0) begin
						idx_q   <= IDX_LAST;
						state_q <= D_BCK_MUL;
					end else begin
						idx_q   <= idx_q - IDX_W'(1);
						state_q <= D_DST_MUL;
					end
				end
				D_BCK_MUL: begin
					mul_q   <= prod;
					st_q    <= st;
					state_q <= D_BCK_UPD;
				end
				D_BCK_UPD: begin
					dst_step_q[idx_q] <= st_q;
					dst_back_q[idx_q] <= mul_q - st_q;
					if (idx_q == '0) begin
						state_q <= D_IDLE;
					end else begin
						idx_q   <= idx_q - IDX_W'(1);
						state_q <= D_BCK_MUL;
					end
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	// outputs
	assign src_step    = src_step_q;
	assign src_back    = src_back_q;
	assign dst_step    = dst_step_q;
	assign dst_back    = dst_back_q;
	assign base        = base_q;
	assign status.busy = (state_q != D_IDLE);
	assign status.done = (state_q == D_BCK_UPD) && (idx_q == '0) && !start;

endmodule

`default_nettype wire
